/* rtl/rrfp_pkg.sv */
// Package for the radar report frame parser: frame constants, parse phases
// and the result record passed from the front parser to the output queue.
// No dependencies.
package rrfp_pkg;

    localparam int unsigned FRAME_BUFFER_BYTES_DEF = 64;
    localparam int unsigned FIELD_DEPTH = 13;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned RPT_MIN_BYTES = 19;
    localparam int unsigned ACK_MIN_BYTES = 6;
    localparam int unsigned ACK_WORD_BYTES = 10;
    localparam int unsigned TDATA_OUT_W = 120;

    localparam logic [31:0] HDR_ACK  = 32'hFDFC_FBFA;
    localparam logic [31:0] TAIL_ACK = 32'h0403_0201;
    localparam logic [31:0] HDR_RPT  = 32'hF4F3_F2F1;
    localparam logic [31:0] TAIL_RPT = 32'hF8F7_F6F5;
    localparam logic [7:0]  RPT_TYPE = 8'h02;
    localparam logic [7:0]  RPT_MARK = 8'hAA;
    localparam logic [6:0]  BYTE_COUNT_MAX = 7'd127;

    localparam logic [1:0] KIND_REPORT  = 2'd0;
    localparam logic [1:0] KIND_ACK_OK  = 2'd1;
    localparam logic [1:0] KIND_ACK_ERR = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_LO = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_ACK    = 3'd3,
        PH_RPT    = 3'd4
    } phase_t;

    typedef struct packed {
        logic [15:0] ack_word;
        logic [15:0] ack_status;
        logic [15:0] ack_command;
        logic [15:0] detect_distance;
        logic [7:0]  still_strength;
        logic [15:0] still_distance;
        logic [7:0]  moving_strength;
        logic [15:0] moving_distance;
        logic [2:0]  target_state;
        logic [1:0]  result_kind;
    } result_t;

endpackage

/* rtl/rrfp_front.sv */
// Front parser: takes one received byte per cycle while take is high, hunts
// for frame headers, gathers frame bytes and emits one result record per good frame.
// Depends on rrfp_pkg.
module rrfp_front #(
    parameter int unsigned FRAME_BUFFER_BYTES = rrfp_pkg::FRAME_BUFFER_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             take,
    input  logic [7:0]       rx_byte,
    output logic             push,
    output rrfp_pkg::result_t push_data
);
    import rrfp_pkg::*;

    localparam logic [16:0] FBB = 17'(FRAME_BUFFER_BYTES);

    phase_t      phase_reg, phase_next;
    logic [31:0] hdr_reg, hdr_next;
    logic [31:0] tail_reg, tail_next;
    logic [15:0] len_reg, len_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [7:0]  field_reg [FIELD_DEPTH];
    logic [7:0]  fv [FIELD_DEPTH];

    logic [31:0] hdr_shift, tail_shift;
    logic [16:0] total, cnt_r, rpt_need;
    logic [15:0] len_dec;
    logic [6:0]  cnt_inc;
    logic        wr_en;
    logic [15:0] wr_pos;
    logic        ack_done, ack_ok, rpt_tail, rpt_ok, rpt_over, len_over;
    logic [15:0] status;

    assign hdr_shift  = {hdr_reg[23:0], rx_byte};
    assign tail_shift = {tail_reg[23:0], rx_byte};
    assign total      = {1'b0, rx_byte, len_reg[7:0]} + 17'd4;
    assign len_over   = total > FBB;
    assign len_dec    = len_reg - 16'd1;
    assign cnt_inc    = (cnt_reg == BYTE_COUNT_MAX) ? BYTE_COUNT_MAX : cnt_reg + 7'd1;
    assign cnt_r      = {1'b0, len_reg} + 17'd1;
    assign wr_en      = (phase_reg == PH_ACK) || (phase_reg == PH_RPT);
    assign wr_pos     = (phase_reg == PH_ACK) ? {9'd0, cnt_reg} : len_reg;

    // Field bytes as they stand once the current byte is stored.
    always_comb begin
        for (int i = 0; i < FIELD_DEPTH; i++) begin
            fv[i] = (wr_en && wr_pos == 16'(i)) ? rx_byte : field_reg[i];
        end
    end

    assign status   = {fv[3], fv[2]};
    assign rpt_need = {1'b0, fv[1], fv[0]} + 17'd6;
    assign ack_done = (phase_reg == PH_ACK) && (len_dec == 16'd0);
    assign ack_ok   = ack_done && (cnt_inc >= 7'(ACK_MIN_BYTES)) && (tail_shift == TAIL_ACK);
    assign rpt_tail = (phase_reg == PH_RPT) && (tail_shift == TAIL_RPT);
    assign rpt_over = (phase_reg == PH_RPT) && !rpt_tail && (cnt_r >= FBB);
    assign rpt_ok   = rpt_tail && (cnt_r >= 17'(RPT_MIN_BYTES)) && (rpt_need <= cnt_r)
                      && (fv[2] == RPT_TYPE) && (fv[3] == RPT_MARK);

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HUNT: begin
                if (hdr_shift == HDR_ACK) phase_next = PH_LEN_LO;
                else if (hdr_shift == HDR_RPT) phase_next = PH_RPT;
            end
            PH_LEN_LO: phase_next = PH_LEN_HI;
            PH_LEN_HI: phase_next = len_over ? PH_HUNT : PH_ACK;
            PH_ACK:    if (ack_done) phase_next = PH_HUNT;
            PH_RPT:    if (rpt_tail || rpt_over) phase_next = PH_HUNT;
            default:   phase_next = PH_HUNT;
        endcase
    end

    // Datapath registers and result.
    always_comb begin
        hdr_next  = hdr_reg;
        tail_next = tail_reg;
        len_next  = len_reg;
        cnt_next  = cnt_reg;
        push      = 1'b0;
        push_data = '0;
        case (phase_reg)
            PH_HUNT: begin
                hdr_next = hdr_shift;
                if (hdr_shift != HDR_ACK && hdr_shift == HDR_RPT) begin
                    len_next  = 16'd0;
                    tail_next = 32'd0;
                end
            end
            PH_LEN_LO: len_next = {8'd0, rx_byte};
            PH_LEN_HI: begin
                if (len_over) begin
                    hdr_next = 32'd0;
                end else begin
                    len_next  = total[15:0];
                    cnt_next  = 7'd0;
                    tail_next = 32'd0;
                end
            end
            PH_ACK: begin
                tail_next = tail_shift;
                cnt_next  = cnt_inc;
                len_next  = len_dec;
                if (ack_done) hdr_next = 32'd0;
                push = take && ack_ok;
                push_data.result_kind = (status != 16'd0) ? KIND_ACK_ERR : KIND_ACK_OK;
                push_data.ack_command = {fv[1], fv[0]};
                push_data.ack_status  = status;
                push_data.ack_word    = (cnt_inc >= 7'(ACK_WORD_BYTES)) ? {fv[5], fv[4]} : 16'd0;
            end
            PH_RPT: begin
                tail_next = tail_shift;
                len_next  = cnt_r[15:0];
                if (rpt_tail || rpt_over) hdr_next = 32'd0;
                push = take && rpt_ok;
                push_data.result_kind     = KIND_REPORT;
                push_data.target_state    = fv[4][2:0];
                push_data.moving_distance = {fv[6], fv[5]};
                push_data.moving_strength = fv[7];
                push_data.still_distance  = {fv[9], fv[8]};
                push_data.still_strength  = fv[10];
                push_data.detect_distance = {fv[12], fv[11]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            hdr_reg   <= 32'd0;
            tail_reg  <= 32'd0;
            len_reg   <= 16'd0;
            cnt_reg   <= 7'd0;
        end else if (take) begin
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
            tail_reg  <= tail_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            for (int i = 0; i < FIELD_DEPTH; i++) field_reg[i] <= fv[i];
        end
    end

    a_push_needs_take: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> take) else $error("result without an accepted byte");
    a_hunt_after_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> (phase_reg == PH_HUNT) && (hdr_reg == 32'd0))
        else $error("parser not back to hunting after a frame");
    a_ack_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ACK) |-> (len_reg != 16'd0))
        else $error("acknowledge length ran out");

endmodule

/* rtl/rrfp_queue.sv */
// Short result queue between the front parser and the output stage.
// Depends on rrfp_pkg.
module rrfp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rrfp_pkg::result_t push_data,
    input  logic              pop,
    output logic              empty,
    output logic              full,
    output rrfp_pkg::result_t head
);
    import rrfp_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    result_t         mem [QUEUE_DEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [PW:0]     cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign head  = mem[rp_reg];
    assign cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + PW'(1);
            if (pop)  rp_reg <= rp_reg + PW'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wp_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("queue underflow");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (PW+1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

/* rtl/rrfp_back.sv */
// Output stage: moves result records from the queue into the result
// register of the master stream. Depends on rrfp_pkg.
module rrfp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              empty,
    input  rrfp_pkg::result_t head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output rrfp_pkg::result_t m_data
);
    import rrfp_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign pop      = !empty && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_tready) begin
            valid_reg <= !empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) data_reg <= head;
    end

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_tready) |=> valid_reg && $stable(data_reg))
        else $error("stalled result changed");
    a_pop_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> valid_reg) else $error("popped record not presented");
    a_no_pop_when_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_tready) |-> !pop) else $error("pop while result held");

endmodule

/* rtl/radar_report_frame_parser.sv */
// Radar report frame parser: one received byte per cycle in, decoded frame
// results out. A result passes through the result queue and the output register.
// Throughput: one byte per cycle; s_tready drops only while the 4-entry
// result queue is full, so the output stall sets the limit.
// Reset (aresetn low, synchronous) returns to header hunting, empties the queue.
module radar_report_frame_parser #(
    parameter int unsigned FRAME_BUFFER_BYTES = rrfp_pkg::FRAME_BUFFER_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [1:0] result_kind, [4:2] target_state, [20:5] moving_distance,
    // [28:21] moving_strength, [44:29] still_distance, [52:45] still_strength,
    // [68:53] detect_distance, [84:69] ack_command, [100:85] ack_status,
    // [116:101] ack_word, [119:117] zero
    output logic [rrfp_pkg::TDATA_OUT_W-1:0] m_tdata
);
    import rrfp_pkg::*;

    logic    take, push, pop, empty, full;
    result_t push_data, head, m_data;

    assign s_tready = !full;
    assign take     = s_tvalid && s_tready;
    assign m_tdata  = {(TDATA_OUT_W - $bits(result_t))'(0), m_data};

    rrfp_front #(.FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)) u_front (
        .aclk, .aresetn, .take, .rx_byte(s_tdata), .push, .push_data
    );

    rrfp_queue u_queue (
        .aclk, .aresetn, .push, .push_data, .pop, .empty, .full, .head
    );

    rrfp_back u_back (
        .aclk, .aresetn, .empty, .head, .pop, .m_tvalid, .m_tready, .m_data
    );

endmodule
